// ===== rtl/core/tof_pkg.sv =====
// ----------------------------------------------------------------------------
// tof_pkg
// Types and codes shared by the two-operand ALU pipeline stages.
// ----------------------------------------------------------------------------
package tof_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned HalfW = DataW / 2;

  typedef enum logic [2:0] {
    KIND_MOV  = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_ADDC = 3'd2,
    KIND_SUBC = 3'd3,
    KIND_SUB  = 3'd4,
    KIND_CMP  = 3'd5
  } kind_e;

  // input beat
  typedef struct packed {
    kind_e              kind;
    logic               byte_mode;
    logic [DataW-1:0]   src_value;
    logic [DataW-1:0]   dst_value;
    logic               carry_in;
  } req_t;

  // result beat
  typedef struct packed {
    logic [DataW-1:0]   result;
    logic               write_back;
    logic               flags_update;
    logic               flag_c;
    logic               flag_z;
    logic               flag_n;
    logic               flag_v;
  } rsp_t;

  // decoded adder operands, stage one to stage two
  typedef struct packed {
    logic               byte_mode;
    logic [DataW-1:0]   opa;
    logic [DataW-1:0]   opb;
    logic               cin;
    logic               write_back;
    logic               flags_update;
  } opd_t;

  // low half done, stage two to stage three
  typedef struct packed {
    logic               byte_mode;
    logic [HalfW-1:0]   opa_hi;
    logic [HalfW-1:0]   opb_hi;
    logic [HalfW-1:0]   sum_lo;
    logic               carry_lo;
    logic               opa_msb_lo;
    logic               opb_msb_lo;
    logic               write_back;
    logic               flags_update;
  } lo_t;

endpackage

// ===== rtl/core/tof_dec.sv =====
// ----------------------------------------------------------------------------
// tof_dec
// Stage one: decodes the operation and forms the adder operands at width.
// ----------------------------------------------------------------------------
module tof_dec
  import tof_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  req_t req_i,
  output logic valid_o,
  output opd_t opd_o
);

  logic [DataW-1:0] mask;
  logic [DataW-1:0] src_m;
  logic [DataW-1:0] dst_m;
  logic             valid_q;
  opd_t             opd_d;
  opd_t             opd_q;

  assign mask  = req_i.byte_mode ? {{HalfW{1'b0}}, {HalfW{1'b1}}} : {DataW{1'b1}};
  assign src_m = req_i.src_value & mask;
  assign dst_m = req_i.dst_value & mask;

  // move runs as 0 + src, no-op codes as dst + 0
  always_comb begin
    opd_d.byte_mode    = req_i.byte_mode;
    opd_d.opa          = dst_m;
    opd_d.opb          = {DataW{1'b0}};
    opd_d.cin          = 1'b0;
    opd_d.write_back   = 1'b1;
    opd_d.flags_update = 1'b1;
    unique case (req_i.kind)
      KIND_MOV: begin
        opd_d.opa          = {DataW{1'b0}};
        opd_d.opb          = src_m;
        opd_d.flags_update = 1'b0;
      end
      KIND_ADD: begin
        opd_d.opb = src_m;
      end
      KIND_ADDC: begin
        opd_d.opb = src_m;
        opd_d.cin = req_i.carry_in;
      end
      KIND_SUBC: begin
        opd_d.opb = ~src_m & mask;
        opd_d.cin = req_i.carry_in;
      end
      KIND_SUB: begin
        opd_d.opb = ~src_m & mask;
        opd_d.cin = 1'b1;
      end
      KIND_CMP: begin
        opd_d.opb        = ~src_m & mask;
        opd_d.cin        = 1'b1;
        opd_d.write_back = 1'b0;
      end
      default: begin
        opd_d.write_back   = 1'b0;
        opd_d.flags_update = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      opd_q <= opd_d;
    end
  end

  assign valid_o = valid_q;
  assign opd_o   = opd_q;

endmodule

// ===== rtl/core/tof_lo.sv =====
// ----------------------------------------------------------------------------
// tof_lo
// Stage two: low byte of the adder, carry handed on to the high byte.
// ----------------------------------------------------------------------------
module tof_lo
  import tof_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  opd_t opd_i,
  output logic valid_o,
  output lo_t  lo_o
);

  logic [HalfW:0] sum;
  logic           valid_q;
  lo_t            lo_d;
  lo_t            lo_q;

  assign sum = {1'b0, opd_i.opa[HalfW-1:0]} + {1'b0, opd_i.opb[HalfW-1:0]}
             + {{HalfW{1'b0}}, opd_i.cin};

  always_comb begin
    lo_d.byte_mode    = opd_i.byte_mode;
    lo_d.opa_hi       = opd_i.opa[DataW-1:HalfW];
    lo_d.opb_hi       = opd_i.opb[DataW-1:HalfW];
    lo_d.sum_lo       = sum[HalfW-1:0];
    lo_d.carry_lo     = sum[HalfW];
    lo_d.opa_msb_lo   = opd_i.opa[HalfW-1];
    lo_d.opb_msb_lo   = opd_i.opb[HalfW-1];
    lo_d.write_back   = opd_i.write_back;
    lo_d.flags_update = opd_i.flags_update;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lo_q <= lo_d;
    end
  end

  assign valid_o = valid_q;
  assign lo_o    = lo_q;

endmodule

// ===== rtl/core/tof_hi.sv =====
// ----------------------------------------------------------------------------
// tof_hi
// Stage three: high byte of the adder, flags at width, result register.
// ----------------------------------------------------------------------------
module tof_hi
  import tof_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  lo_t  lo_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic [HalfW:0] sum;
  logic           a_msb;
  logic           b_msb;
  logic           r_msb;
  logic           valid_q;
  rsp_t           rsp_d;
  rsp_t           rsp_q;

  // in byte mode the high operands are zero, so only the low half counts
  assign sum = {1'b0, lo_i.opa_hi} + {1'b0, lo_i.opb_hi} + {{HalfW{1'b0}}, lo_i.carry_lo};

  assign a_msb = lo_i.byte_mode ? lo_i.opa_msb_lo : lo_i.opa_hi[HalfW-1];
  assign b_msb = lo_i.byte_mode ? lo_i.opb_msb_lo : lo_i.opb_hi[HalfW-1];
  assign r_msb = lo_i.byte_mode ? lo_i.sum_lo[HalfW-1] : sum[HalfW-1];

  always_comb begin
    rsp_d.result       = lo_i.byte_mode ? {{HalfW{1'b0}}, lo_i.sum_lo}
                                        : {sum[HalfW-1:0], lo_i.sum_lo};
    rsp_d.write_back   = lo_i.write_back;
    rsp_d.flags_update = lo_i.flags_update;
    rsp_d.flag_c       = 1'b0;
    rsp_d.flag_z       = 1'b0;
    rsp_d.flag_n       = 1'b0;
    rsp_d.flag_v       = 1'b0;
    if (lo_i.flags_update) begin
      rsp_d.flag_c = lo_i.byte_mode ? lo_i.carry_lo : sum[HalfW];
      rsp_d.flag_z = (rsp_d.result == '0);
      rsp_d.flag_n = r_msb;
      rsp_d.flag_v = (a_msb == b_msb) && (a_msb != r_msb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/core/two_operand_alu_flags.sv =====
// ----------------------------------------------------------------------------
// two_operand_alu_flags
// Byte/word move, add, add/sub with carry, sub and compare with C Z N V flags.
// ----------------------------------------------------------------------------
//  channel   handshake          beat
//  request   start / busy       req_i  (req_t)
//  result    done_o strobe      rsp_o  (rsp_t)
//
//  three register stages: decode, low-byte add, high-byte add and flags
//  a beat taken by the decode register passes the low-byte and high-byte
//  registers and is then on rsp_o with done_o, where the receiver takes it
//  one beat per cycle sustained; busy stays low, nothing ever stalls
//  the result stage is the output register, valid for exactly one cycle
//  reset clears the stage valid bits only; no results are lost to it later
// ----------------------------------------------------------------------------
module two_operand_alu_flags
  import tof_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  logic accept;
  logic dec_valid;
  opd_t dec_opd;
  logic lo_valid;
  lo_t  lo_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tof_dec u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .valid_o (dec_valid),
    .opd_o   (dec_opd)
  );

  tof_lo u_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .opd_i   (dec_opd),
    .valid_o (lo_valid),
    .lo_o    (lo_data)
  );

  tof_hi u_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lo_valid),
    .lo_i    (lo_data),
    .valid_o (done_o),
    .rsp_o   (rsp_o)
  );

  // flags stay clear when they are not written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.flags_update |->
      !rsp_o.flag_c && !rsp_o.flag_z && !rsp_o.flag_n && !rsp_o.flag_v)
    else $error("flags set without flags_update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.flags_update |-> rsp_o.flag_z == (rsp_o.result == '0))
    else $error("zero flag does not match result");

  // a word-width result with a set high byte takes N from bit 15
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.flags_update && (rsp_o.result[DataW-1:HalfW] != '0) |->
      rsp_o.flag_n == rsp_o.result[DataW-1])
    else $error("negative flag does not match result");

  // a result beat never carries unknown bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(rsp_o))
    else $error("result beat has unknown bits");

endmodule

// ===== dv/tof_alu_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// tof_alu_sb_pkg
// Flag-accurate prediction of the two-operand ALU and an in-order result
// scoreboard: every request beat queues its expected result, every result
// beat is compared field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
package tof_alu_sb_pkg;
  import tof_pkg::*;

  localparam logic [15:0] WordMask = 16'hFFFF;
  localparam logic [15:0] ByteMask = 16'h00FF;
  localparam logic [15:0] WordMsb  = 16'h8000;
  localparam logic [15:0] ByteMsb  = 16'h0080;
  localparam int unsigned ReportMax = 10;

  function automatic rsp_t alu_outcome(req_t r);
    logic [15:0] mask;
    logic [15:0] msb;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] addend;
    logic [15:0] res;
    logic [16:0] sum;
    logic        cin;
    rsp_t        o;
    mask   = r.byte_mode ? ByteMask : WordMask;
    msb    = r.byte_mode ? ByteMsb : WordMsb;
    src    = r.src_value & mask;
    dst    = r.dst_value & mask;
    o      = '0;
    o.write_back   = 1'b1;
    o.flags_update = 1'b1;
    case (r.kind)
      KIND_MOV: begin
        o.result       = src;
        o.flags_update = 1'b0;
      end
      KIND_ADD, KIND_ADDC, KIND_SUBC, KIND_SUB, KIND_CMP: begin
        // subtraction is dst + ~src + cin at operation width
        if (r.kind == KIND_ADD || r.kind == KIND_ADDC) begin
          addend = src;
        end else begin
          addend = ~src & mask;
        end
        if (r.kind == KIND_ADD) begin
          cin = 1'b0;
        end else if (r.kind == KIND_ADDC || r.kind == KIND_SUBC) begin
          cin = r.carry_in;
        end else begin
          cin = 1'b1;
        end
        sum      = {1'b0, dst} + {1'b0, addend} + {16'h0000, cin};
        res      = sum[15:0] & mask;
        o.result = res;
        o.flag_c = r.byte_mode ? sum[8] : sum[16];
        o.flag_z = (res == 16'h0000);
        o.flag_n = |(res & msb);
        o.flag_v = |(~(dst ^ addend) & (dst ^ res) & msb);
        o.write_back = (r.kind != KIND_CMP);
      end
      default: begin
        o.result       = dst;
        o.write_back   = 1'b0;
        o.flags_update = 1'b0;
      end
    endcase
    return o;
  endfunction

  class alu_scoreboard;
    rsp_t        pending_q[$];
    int unsigned requests;
    int unsigned results;
    int unsigned mismatches;

    function new();
      requests   = 0;
      results    = 0;
      mismatches = 0;
    endfunction

    function void note_request(req_t r);
      pending_q.push_back(alu_outcome(r));
      requests++;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_q.size() == 0) begin
        flag_error("result beat with nothing pending", '0, got);
        return;
      end
      want = pending_q.pop_front();
      results++;
      if (got.result !== want.result || got.write_back !== want.write_back ||
          got.flags_update !== want.flags_update || got.flag_c !== want.flag_c ||
          got.flag_z !== want.flag_z || got.flag_n !== want.flag_n ||
          got.flag_v !== want.flag_v) begin
        flag_error("result beat mismatch", want, got);
      end
    endfunction

    function void flag_error(string why, rsp_t want, rsp_t got);
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("[%0t] %s", $time, why);
        $display("  expected res=%h wb=%b fu=%b c=%b z=%b n=%b v=%b", want.result,
                 want.write_back, want.flags_update, want.flag_c, want.flag_z,
                 want.flag_n, want.flag_v);
        $display("  actual   res=%h wb=%b fu=%b c=%b z=%b n=%b v=%b", got.result,
                 got.write_back, got.flags_update, got.flag_c, got.flag_z,
                 got.flag_n, got.flag_v);
      end
    endfunction

    function void check_drained();
      if (pending_q.size() != 0) begin
        mismatches += pending_q.size();
        $display("[%0t] %0d expected result beats never arrived", $time,
                 pending_q.size());
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for two_operand_alu_flags: directed corner beats for every
// operation and width, then random beats under several sender idling
// phases, each result checked in order against the predicted flags.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tof_pkg::*;
  import tof_alu_sb_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  alu_scoreboard sb = new();
  int unsigned   idle_cycles = 0;

  always #4 clk = ~clk;

  two_operand_alu_flags dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || done)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_n && start && !busy) begin
      sb.note_request(req);
    end
    if (rst_n && done) begin
      sb.check_result(rsp);
    end
    if (idle_cycles >= StallLimit) begin
      $display("[%0t] no beat accepted for %0d cycles", $time, StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_t make_req(kind_e k, logic bm, logic [15:0] s, logic [15:0] d,
                                    logic c);
    req_t r;
    r.kind      = k;
    r.byte_mode = bm;
    r.src_value = s;
    r.dst_value = d;
    r.carry_in  = c;
    return r;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = 16'h7FFF;
        3: v = 16'h8000;
        4: v = 16'h00FF;
        5: v = 16'h0080;
        6: v = 16'h007F;
        default: v = 16'h0001;
      endcase
      // junk in the upper byte for byte-width beats
      if ($urandom_range(1) == 1) begin
        v[15:8] = 8'($urandom_range(255));
      end
    end else begin
      v = 16'($urandom_range(16'hFFFF));
    end
    return v;
  endfunction

  task automatic send_beat(req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned idle_pct [3];
    int unsigned beats [3];
    req_t        r;
    idle_pct = '{0, 75, 10};
    beats    = '{520, 520, 510};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // move ignores flags; upper byte dropped in byte mode
    send_beat(make_req(KIND_MOV, 1'b0, 16'hFFFF, 16'h1234, 1'b1));
    send_beat(make_req(KIND_MOV, 1'b1, 16'hAB80, 16'hFFFF, 1'b0));
    send_beat(make_req(KIND_MOV, 1'b0, 16'h0000, 16'h0000, 1'b0));
    // add: overflow, carry out to zero, both
    send_beat(make_req(KIND_ADD, 1'b0, 16'h0001, 16'h7FFF, 1'b1));
    send_beat(make_req(KIND_ADD, 1'b0, 16'h0001, 16'hFFFF, 1'b0));
    send_beat(make_req(KIND_ADD, 1'b0, 16'h8000, 16'h8000, 1'b0));
    send_beat(make_req(KIND_ADD, 1'b1, 16'h3401, 16'h127F, 1'b0));
    send_beat(make_req(KIND_ADD, 1'b1, 16'hFF01, 16'hAAFF, 1'b1));
    // add with carry, carry flag used both ways
    send_beat(make_req(KIND_ADDC, 1'b0, 16'h0000, 16'hFFFF, 1'b1));
    send_beat(make_req(KIND_ADDC, 1'b0, 16'h4321, 16'h1234, 1'b0));
    send_beat(make_req(KIND_ADDC, 1'b1, 16'h007F, 16'h0000, 1'b1));
    // sub with carry: no carry means an extra borrow
    send_beat(make_req(KIND_SUBC, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_beat(make_req(KIND_SUBC, 1'b0, 16'h0000, 16'h0000, 1'b1));
    send_beat(make_req(KIND_SUBC, 1'b1, 16'h5501, 16'h6680, 1'b1));
    send_beat(make_req(KIND_SUBC, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
    // sub: signed overflow, borrow, equal operands
    send_beat(make_req(KIND_SUB, 1'b0, 16'h0001, 16'h8000, 1'b0));
    send_beat(make_req(KIND_SUB, 1'b0, 16'h0001, 16'h0000, 1'b1));
    send_beat(make_req(KIND_SUB, 1'b1, 16'h0001, 16'h0080, 1'b0));
    send_beat(make_req(KIND_SUB, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0));
    // compare keeps the difference but does not write back
    send_beat(make_req(KIND_CMP, 1'b0, 16'h5555, 16'h5555, 1'b0));
    send_beat(make_req(KIND_CMP, 1'b1, 16'h12FF, 16'h347F, 1'b1));
    send_beat(make_req(KIND_CMP, 1'b0, 16'h8000, 16'h7FFF, 1'b0));
    send_beat(make_req(KIND_CMP, 1'b1, 16'h0000, 16'h0000, 1'b0));

    for (int p = 0; p < 3; p++) begin
      for (int unsigned i = 0; i < beats[p]; i++) begin
        sender_gap(idle_pct[p]);
        r = make_req(kind_e'($urandom_range(5)), 1'($urandom_range(1)), pick_operand(),
                     pick_operand(), 1'($urandom_range(1)));
        send_beat(r);
      end
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    sb.check_drained();

    $display("covered %0d request beats of all six operations at both widths,", sb.requests);
    $display("over phases with no idling, 75%% and 10%% sender idling; %0d results checked",
             sb.results);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
